### rtl/core/icfc_pkg.sv
// Package for the IEEE single / DSP float converter.
// Holds field constants, the two conversion functions and a convert dispatcher; no dependencies.
package icfc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;

  localparam logic [ExpW-1:0]  ExpIeeeZero = 8'h00;
  localparam logic [ExpW-1:0]  ExpIeeeMax  = 8'hff;
  localparam logic [ExpW-1:0]  ExpBias     = 8'h7f;
  localparam logic [ExpW-1:0]  ExpBiasPow2 = 8'h80;
  localparam logic [ExpW-1:0]  ExpDspZero  = 8'h80;
  localparam logic [ExpW-1:0]  ExpDspTiny  = 8'h81;
  localparam logic [ExpW-1:0]  ExpDspMax   = 8'h7f;
  localparam logic [FracW-1:0] FracAll     = 23'h7fffff;
  localparam logic [FracW-1:0] FracNone    = 23'h000000;

  typedef enum logic {
    DIR_IEEE_TO_DSP = 1'b0,
    DIR_DSP_TO_IEEE = 1'b1
  } dir_t;

  function automatic logic [WordW-1:0] ieee_to_dsp(input logic [WordW-1:0] w);
    logic [ExpW-1:0]  e;
    logic             s;
    logic [FracW-1:0] f;
    logic [ExpW-1:0]  ed;
    logic             sd;
    logic [FracW-1:0] fd;
    e = w[30:23];
    s = w[31];
    f = w[FracW-1:0];
    if (e == ExpIeeeZero) begin
      ed = ExpDspZero; sd = 1'b0; fd = FracNone;
    end else if (e == ExpIeeeMax && s) begin
      ed = ExpDspMax; sd = 1'b1; fd = FracNone;
    end else if (e == ExpIeeeMax) begin
      ed = ExpDspMax; sd = 1'b0; fd = FracAll;
    end else if (!s) begin
      ed = e - ExpBias; sd = 1'b0; fd = f;
    end else if (f != FracNone) begin
      ed = e - ExpBias; sd = 1'b1; fd = FracNone - f;
    end else begin
      ed = e - ExpBiasPow2; sd = 1'b1; fd = FracNone;
    end
    return {ed, sd, fd};
  endfunction

  function automatic logic [WordW-1:0] dsp_to_ieee(input logic [WordW-1:0] w);
    logic [ExpW-1:0]  ed;
    logic             sd;
    logic [FracW-1:0] fd;
    logic [ExpW-1:0]  ei;
    logic             si;
    logic [FracW-1:0] fi;
    ed = w[31:24];
    sd = w[23];
    fd = w[FracW-1:0];
    if (ed == ExpDspZero || ed == ExpDspTiny) begin
      ei = ExpIeeeZero; si = 1'b0; fi = FracNone;
    end else if (ed == ExpDspMax && sd && fd == FracNone) begin
      ei = ExpIeeeMax; si = 1'b1; fi = FracNone;
    end else if (!sd) begin
      ei = ed + ExpBias; si = 1'b0; fi = fd;
    end else if (fd != FracNone) begin
      ei = ed + ExpBias; si = 1'b1; fi = FracNone - fd;
    end else begin
      ei = ed + ExpBiasPow2; si = 1'b1; fi = FracNone;
    end
    return {si, ei, fi};
  endfunction

  function automatic logic [WordW-1:0] convert(input dir_t dir,
                                               input logic [WordW-1:0] w);
    return (dir == DIR_DSP_TO_IEEE) ? dsp_to_ieee(w) : ieee_to_dsp(w);
  endfunction

endpackage

### rtl/core/icfc_if.sv
// Valid/ready channel interfaces for the converter: request and result.
// Depends on icfc_pkg for the word width.
interface icfc_req_if;
  import icfc_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [WordW-1:0] data_word;
  modport source (output valid, output req_type, output data_word, input ready);
  modport sink   (input valid, input req_type, input data_word, output ready);
endinterface

interface icfc_rsp_if;
  import icfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result_word;
  modport source (output valid, output result_word, input ready);
  modport sink   (input valid, input result_word, output ready);
endinterface

### rtl/core/ieee_c4x_float_converter_unit.sv
// Top level of the IEEE single / DSP float converter, two register stages.
// Depends on icfc_pkg and the channel interfaces in icfc_if.sv.
//
//   channel  dir  payload                      transfer when
//   req      in   req_type, data_word          req.valid & req.ready
//   rsp      out  result_word                  rsp.valid & rsp.ready
//
// One word per cycle sustained while rsp is ready; a word transferred in is
// held in the input register, then passes through the conversion logic into
// the result register, from which it can transfer out.
// Reset clears both stage valid bits only.
// A stalled rsp holds the result register; req stays ready until both stages
// are full, so one new word is taken while a finished result waits.
module ieee_c4x_float_converter_unit (
  input  logic       clk,
  input  logic       rst,
  icfc_req_if.sink   req,
  icfc_rsp_if.source rsp
);
  import icfc_pkg::*;

  logic             in_valid;
  dir_t             in_dir;
  logic [WordW-1:0] in_word;
  logic             out_valid;
  logic [WordW-1:0] out_word;
  logic             adv_out;
  logic             adv_in;

  assign adv_out   = !out_valid || rsp.ready;
  assign adv_in    = !in_valid || adv_out;
  assign req.ready = adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && req.valid) begin
      in_dir  <= dir_t'(req.req_type);
      in_word <= req.data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_valid) begin
      out_word <= convert(in_dir, in_word);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_word = out_word;

`ifndef SYNTHESIS
  a_ready_only_low_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> in_valid && out_valid && !rsp.ready)
    else $error("req stalled while a stage is free");

  a_result_matches_stage: assert property (@(posedge clk) disable iff (rst)
    adv_out && in_valid |=> out_valid && out_word == convert($past(in_dir), $past(in_word)))
    else $error("result register does not hold the converted word");

  a_no_positive_inf: assert property (@(posedge clk) disable iff (rst)
    adv_out && in_valid && in_dir == DIR_DSP_TO_IEEE
    |=> !(out_word[31] == 1'b0 && out_word[30:23] == ExpIeeeMax))
    else $error("DSP to IEEE produced positive infinity or NaN");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("stage valid set after reset");
`endif

endmodule
